// File: design/refcount_compacting_allocator_top_assert.svh
// Assertion macros for the refcount compacting allocator.
`ifndef REFCOUNT_COMPACTING_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNT_COMPACTING_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RCA_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RCA_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define RCA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: design/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and codes of the refcount compacting allocator.
// ----------------------------------------------------------------------------
package rca_pkg;
   localparam int POOL_BYTES  = 65536;
   localparam int MAX_OBJECTS = 64;

   localparam logic [2:0] CMD_INSERT   = 3'd0;
   localparam logic [2:0] CMD_RETRIEVE = 3'd1;
   localparam logic [2:0] CMD_ADDREF   = 3'd2;
   localparam logic [2:0] CMD_DROPREF  = 3'd3;
   localparam logic [2:0] CMD_INIT     = 3'd4;
   localparam logic [2:0] CMD_DESTROY  = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_NO_SPACE  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NO_POOL   = 3'd4;
   localparam logic [2:0] ST_OPEN      = 3'd5;

   // Listed from the top bit down, so cmd sits in the lowest bits.
   typedef struct packed {
      logic [31:0] ref_id;
      logic [16:0] alloc_size;
      logic [2:0]  cmd;
   } cmd_type;

   localparam int CMD_W = 52;
endpackage

// File: design/rca_front.sv
// ----------------------------------------------------------------------------
// rca_front
// Accepts command beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rca_front
   import rca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= in_cmd;
   end
endmodule

// File: design/rca_back.sv
// ----------------------------------------------------------------------------
// rca_back
// Executes commands against the object table, walking its entries one at a time.
// ----------------------------------------------------------------------------
module rca_back
   import rca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           cmd_valid,
   output logic           cmd_ready,
   input  cmd_type        cmd,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [2:0]     rsp_status,
   output logic [31:0]    rsp_new_id,
   output logic [15:0]    rsp_offset,
   output logic           rsp_compacted,
   output logic [16:0]    rsp_bytes,
   output logic [6:0]     rsp_count
);
   localparam int IW = $clog2(MAX_OBJECTS);
   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam int PW = $clog2(POOL_BYTES + 1);
   localparam logic [PW-1:0] POOL = PW'(POOL_BYTES);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_CMP, S_SHIFT, S_SHW, S_COMPACT, S_CPW, S_ALLOC, S_OUT
   } state_type;

   state_type     state_ff;
   cmd_type       c_ff;
   logic [31:0]   id_mem [MAX_OBJECTS];
   logic [PW-1:0] st_mem [MAX_OBJECTS];
   logic [PW-1:0] sz_mem [MAX_OBJECTS];
   logic [15:0]   rf_mem [MAX_OBJECTS];
   logic [PW-1:0] free_ff, pos_ff;
   logic [31:0]   next_ff;
   logic [CW-1:0] live_ff, i_ff;
   logic          open_ff, comp_ff;
   logic [2:0]    status_ff;
   logic [31:0]   nid_ff;
   logic [15:0]   off_ff;
   logic [31:0]   rd_id_ff;
   logic [PW-1:0] rd_st_ff, rd_sz_ff;
   logic [15:0]   rd_rf_ff;
   logic [IW-1:0] idx, raddr;
   logic [PW-1:0] remain;
   logic          insert_go, too_short;

   assign idx       = i_ff[IW-1:0];
   // The shift reads the entry above the one it overwrites.
   assign raddr     = (state_ff == S_SHIFT) ? IW'(i_ff + CW'(1)) : idx;
   assign remain    = POOL - free_ff;
   assign insert_go = open_ff && (cmd.cmd == CMD_INSERT) && (live_ff < CW'(MAX_OBJECTS));
   assign too_short = ({1'b0, remain} < 18'(cmd.alloc_size));
   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = status_ff;
   assign rsp_new_id = nid_ff;
   assign rsp_offset = off_ff;
   assign rsp_compacted = comp_ff;
   assign rsp_bytes = 17'(free_ff);
   assign rsp_count = 7'(live_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '0;
         next_ff  <= 32'd1;
         live_ff  <= '0;
         open_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               c_ff    <= cmd;
               nid_ff  <= '0;
               off_ff  <= '0;
               comp_ff <= insert_go && too_short;
               i_ff    <= '0;
               pos_ff  <= '0;
               priority if (cmd.cmd <= CMD_DROPREF && !open_ff) begin
                  status_ff <= ST_NO_POOL;
                  state_ff  <= S_OUT;
               end else if (cmd.cmd == CMD_INSERT) begin
                  if (!insert_go) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_OUT;
                  end else begin
                     status_ff <= ST_OK;
                     state_ff  <= too_short ? S_COMPACT : S_ALLOC;
                  end
               end else if (cmd.cmd <= CMD_DROPREF) begin
                  status_ff <= ST_OK;
                  state_ff  <= S_FIND;
               end else if (cmd.cmd == CMD_INIT) begin
                  status_ff <= open_ff ? ST_OPEN : ST_OK;
                  open_ff   <= 1'b1;
                  state_ff  <= S_OUT;
               end else if (cmd.cmd == CMD_DESTROY) begin
                  status_ff <= open_ff ? ST_OK : ST_NO_POOL;
                  state_ff  <= S_OUT;
                  if (open_ff) begin
                     open_ff <= 1'b0;
                     free_ff <= '0;
                     next_ff <= 32'd1;
                     live_ff <= '0;
                  end
               end else begin
                  status_ff <= ST_OK;
                  state_ff  <= S_OUT;
               end
            end
            S_FIND: begin
               if (i_ff >= live_ff) begin
                  status_ff <= ST_NOT_FOUND;
                  state_ff <= S_OUT;
               end else state_ff <= S_CMP;
            end
            S_CMP: begin
               if (rd_id_ff == c_ff.ref_id) begin
                  off_ff <= 16'(rd_st_ff);
                  if (c_ff.cmd == CMD_DROPREF && rd_rf_ff <= 16'd1) state_ff <= S_SHIFT;
                  else state_ff <= S_OUT;
                  if (c_ff.cmd == CMD_ADDREF && rd_rf_ff != 16'hFFFF)
                     rf_mem[idx] <= rd_rf_ff + 16'd1;
                  else if (c_ff.cmd == CMD_DROPREF && rd_rf_ff > 16'd1)
                     rf_mem[idx] <= rd_rf_ff - 16'd1;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_FIND;
               end
            end
            S_SHIFT: begin
               // Move the next entry down one slot until the end of the table.
               if (i_ff + CW'(1) < live_ff) state_ff <= S_SHW;
               else begin
                  live_ff <= live_ff - CW'(1);
                  state_ff <= S_OUT;
               end
            end
            S_SHW: begin
               id_mem[idx] <= rd_id_ff;
               st_mem[idx] <= rd_st_ff;
               sz_mem[idx] <= rd_sz_ff;
               rf_mem[idx] <= rd_rf_ff;
               i_ff <= i_ff + CW'(1);
               state_ff <= S_SHIFT;
            end
            S_COMPACT: begin
               if (i_ff < live_ff) state_ff <= S_CPW;
               else begin
                  free_ff <= pos_ff;
                  state_ff <= S_ALLOC;
               end
            end
            S_CPW: begin
               st_mem[idx] <= pos_ff;
               pos_ff <= pos_ff + rd_sz_ff;
               i_ff <= i_ff + CW'(1);
               state_ff <= S_COMPACT;
            end
            S_ALLOC: begin
               state_ff <= S_OUT;
               if ({1'b0, remain} < 18'(c_ff.alloc_size)) status_ff <= ST_NO_SPACE;
               else begin
                  id_mem[IW'(live_ff)] <= next_ff;
                  st_mem[IW'(live_ff)] <= free_ff;
                  sz_mem[IW'(live_ff)] <= PW'(c_ff.alloc_size);
                  rf_mem[IW'(live_ff)] <= 16'd1;
                  live_ff <= live_ff + CW'(1);
                  nid_ff <= next_ff;
                  off_ff <= 16'(free_ff);
                  free_ff <= free_ff + PW'(c_ff.alloc_size);
                  next_ff <= (next_ff == 32'hFFFFFFFF) ? 32'd1 : next_ff + 32'd1;
               end
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
      rd_id_ff <= id_mem[raddr];
      rd_st_ff <= st_mem[raddr];
      rd_sz_ff <= sz_mem[raddr];
      rd_rf_ff <= rf_mem[raddr];
   end
endmodule

// File: design/refcount_compacting_allocator_top.sv
// Init, destroy, refusals and unused commands are answered directly; an insert
// allocates after a compaction pass if needed. A lookup walks the live entries one
// at a time until it hits or runs past the last one; a drop to zero then shifts each
// following entry down one slot, and compaction repacks every live entry from zero.
// Only one command is in execution at a time.
// Reset: synchronous; the pool is closed and the table empty after reset.
// ----------------------------------------------------------------------------
// refcount_compacting_allocator_top
// Reference-counted bump allocator with compaction, metadata only.
// ----------------------------------------------------------------------------
`include "refcount_compacting_allocator_top_assert.svh"
module refcount_compacting_allocator_top
   import rca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // cmd[2:0], alloc_size[19:3], ref_id[51:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // status, new_id, offset, compacted, bytes, count
);
   cmd_type     q_cmd;
   logic        q_valid, q_ready;
   logic [2:0]  st;
   logic [31:0] nid;
   logic [15:0] off;
   logic        comp;
   logic [16:0] bytes;
   logic [6:0]  cnt;

   rca_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(cmd_type'(req_tdata[CMD_W-1:0])),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   rca_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_status(st), .rsp_new_id(nid), .rsp_offset(off),
      .rsp_compacted(comp), .rsp_bytes(bytes), .rsp_count(cnt)
   );

   assign rsp_tdata = {4'd0, cnt, bytes, comp, off, nid, st};

   `RCA_ASSERT_IMPL(a_count_max, clock, reset, (cnt <= 7'(MAX_OBJECTS)), "too many objects")
   `RCA_ASSERT_IMPL(a_full_nocomp, clock, reset, (rsp_tvalid && st == ST_FULL) |-> !comp, "compaction on full table")
   `RCA_ASSERT_IMPL(a_fail_noid, clock, reset, (rsp_tvalid && st != ST_OK) |-> (nid == 32'd0), "id on failure")
endmodule

// File: tb/allocator_checker.sv
// ----------------------------------------------------------------------------
// allocator_checker
// Watches both streams of the allocator, keeps its own copy of the object
// table, predicts each response beat and compares it field by field.
// ----------------------------------------------------------------------------
module allocator_checker
   import rca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Listed from the top bit down, so status sits in the lowest bits.
   typedef struct packed {
      logic [6:0]  object_count;
      logic [16:0] bytes_in_use;
      logic        compacted;
      logic [15:0] offset;
      logic [31:0] new_id;
      logic [2:0]  status;
   } alloc_result_type;

   // Shadow copy of the object table; slots below obj_count are live.
   logic [31:0] obj_id    [MAX_OBJECTS];
   logic [16:0] obj_start [MAX_OBJECTS];
   logic [16:0] obj_size  [MAX_OBJECTS];
   logic [15:0] obj_refs  [MAX_OBJECTS];
   int unsigned obj_count;
   int unsigned bump_ptr;
   logic [31:0] id_counter;
   logic        is_open;

   alloc_result_type expected_results[$];

   function automatic alloc_result_type apply_command(logic [2:0] cmd, logic [16:0] size,
                                                      logic [31:0] rid);
      alloc_result_type r;
      int slot;
      int unsigned pos;
      r = '0;
      slot = -1;
      if (cmd <= CMD_DROPREF && !is_open) begin
         r.status = ST_NO_POOL;
      end else if (cmd == CMD_INSERT) begin
         if (obj_count >= MAX_OBJECTS) begin
            r.status = ST_FULL;
         end else begin
            if (POOL_BYTES - bump_ptr < size) begin
               pos = 0;
               for (int i = 0; i < obj_count; i++) begin
                  obj_start[i] = 17'(pos);
                  pos += obj_size[i];
               end
               bump_ptr = pos;
               r.compacted = 1'b1;
            end
            if (POOL_BYTES - bump_ptr < size) begin
               r.status = ST_NO_SPACE;
            end else begin
               obj_id[obj_count]    = id_counter;
               obj_start[obj_count] = 17'(bump_ptr);
               obj_size[obj_count]  = size;
               obj_refs[obj_count]  = 16'd1;
               obj_count++;
               r.new_id = id_counter;
               r.offset = bump_ptr[15:0];
               bump_ptr += size;
               id_counter = (id_counter == 32'hFFFF_FFFF) ? 32'd1 : id_counter + 32'd1;
            end
         end
      end else if (cmd <= CMD_DROPREF) begin
         for (int i = 0; i < obj_count; i++) begin
            if (slot < 0 && obj_id[i] == rid) slot = i;
         end
         if (slot < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            r.offset = obj_start[slot][15:0];
            if (cmd == CMD_ADDREF) begin
               if (obj_refs[slot] != 16'hFFFF) obj_refs[slot]++;
            end else if (cmd == CMD_DROPREF) begin
               if (obj_refs[slot] != 0) obj_refs[slot]--;
               if (obj_refs[slot] == 0) begin
                  for (int i = slot; i + 1 < obj_count; i++) begin
                     obj_id[i]    = obj_id[i + 1];
                     obj_start[i] = obj_start[i + 1];
                     obj_size[i]  = obj_size[i + 1];
                     obj_refs[i]  = obj_refs[i + 1];
                  end
                  obj_count--;
               end
            end
         end
      end else if (cmd == CMD_INIT) begin
         if (is_open) r.status = ST_OPEN;
         else is_open = 1'b1;
      end else if (cmd == CMD_DESTROY) begin
         if (!is_open) begin
            r.status = ST_NO_POOL;
         end else begin
            obj_count  = 0;
            bump_ptr   = 0;
            id_counter = 32'd1;
            is_open    = 1'b0;
         end
      end
      r.bytes_in_use = bump_ptr[16:0];
      r.object_count = obj_count[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         obj_count  = 0;
         bump_ptr   = 0;
         id_counter = 32'd1;
         is_open    = 1'b0;
         fail_count = 0;
         expected_results.delete();
         pending    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[75:0];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, got);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
               if (got.new_id !== want.new_id)
                  $display("%0t: new_id expected %0d actual %0d", $time,
                           want.new_id, got.new_id);
               if (got.offset !== want.offset)
                  $display("%0t: offset expected %0d actual %0d", $time,
                           want.offset, got.offset);
               if (got.compacted !== want.compacted)
                  $display("%0t: compacted expected %0d actual %0d", $time,
                           want.compacted, got.compacted);
               if (got.bytes_in_use !== want.bytes_in_use)
                  $display("%0t: bytes_in_use expected %0d actual %0d", $time,
                           want.bytes_in_use, got.bytes_in_use);
               if (got.object_count !== want.object_count)
                  $display("%0t: object_count expected %0d actual %0d", $time,
                           want.object_count, got.object_count);
               if (got !== want) fail_count++;
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_command(req_tdata[2:0], req_tdata[19:3],
                                                     req_tdata[51:20]));
         pending = expected_results.size();
      end
   end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into the allocator with random gaps and response
// back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench
   import rca_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_CMDS = 460;
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          gaps_on = 1'b1;
   bit          pool_is_open = 1'b0;
   int unsigned ids_issued = 0;

   refcount_compacting_allocator_top dut (.*);

   allocator_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 16);

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_cmd(logic [2:0] cmd, logic [16:0] size, logic [31:0] rid);
      while (gaps_on && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, rid, size, cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (cmd == CMD_INSERT) ids_issued++;
      if (cmd == CMD_DESTROY) begin
         ids_issued = 0;
         pool_is_open = 1'b0;
      end
      if (cmd == CMD_INIT) pool_is_open = 1'b1;
   endtask

   function automatic logic [16:0] pick_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 17'($urandom_range(0, 2048));
      if (p < 90) return 17'($urandom_range(4096, 40000));
      if (p < 95) return 17'($urandom_range(0, 17'h1FFFF));
      return 17'd65536;
   endfunction

   function automatic logic [31:0] pick_id();
      if ($urandom_range(0, 19) == 0) return $urandom();
      return $urandom_range(1, ids_issued + 1);
   endfunction

   initial begin
      int p;
      logic [2:0] cmd;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Everything on a closed pool is refused.
      send_cmd(CMD_DESTROY, 0, 0);
      send_cmd(CMD_INSERT, 17'h1FFFF, 32'hFFFF_FFFF);
      send_cmd(CMD_RETRIEVE, 0, 1);
      send_cmd(CMD_ADDREF, 0, 1);
      send_cmd(CMD_DROPREF, 0, 1);
      send_cmd(CMD_INIT, 0, 0);
      send_cmd(CMD_INIT, 0, 0);
      send_cmd(CMD_INSERT, 0, 0);
      send_cmd(CMD_INSERT, 17'd65536, 0);
      // No room even after repacking.
      send_cmd(CMD_INSERT, 1, 0);
      send_cmd(CMD_RETRIEVE, 0, 1);
      send_cmd(CMD_RETRIEVE, 0, 32'hFFFF_FFFF);
      send_cmd(CMD_ADDREF, 0, 2);
      send_cmd(CMD_DROPREF, 0, 2);
      send_cmd(CMD_DROPREF, 0, 2);
      send_cmd(CMD_DROPREF, 0, 1);
      send_cmd(CMD_SPARE_A, 17'h1FFFF, 32'hFFFF_FFFF);
      send_cmd(CMD_SPARE_B, 0, 0);
      send_cmd(CMD_INSERT, 17'h1FFFF, 0);
      // Fill the table, then one insert past full.
      for (int i = 0; i <= MAX_OBJECTS; i++) send_cmd(CMD_INSERT, 1, 0);
      // A few back-to-back reference bumps on one entry.
      gaps_on = 1'b0;
      for (int i = 0; i < 8; i++) send_cmd(CMD_ADDREF, 0, 3);
      gaps_on = 1'b1;
      send_cmd(CMD_DESTROY, 0, 0);

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         gaps_on = !(n >= 200 && n < 300);
         p = $urandom_range(0, 99);
         if (!pool_is_open && p < 85) cmd = CMD_INIT;
         else if (p < 40) cmd = CMD_INSERT;
         else if (p < 55) cmd = CMD_RETRIEVE;
         else if (p < 70) cmd = CMD_ADDREF;
         else if (p < 90) cmd = CMD_DROPREF;
         else if (p < 93) cmd = CMD_DESTROY;
         else if (p < 96) cmd = CMD_INIT;
         else cmd = 3'($urandom_range(0, 7));
         send_cmd(cmd, pick_size(), pick_id());
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Covered closed-pool refusals, a full table, compaction, removal by drop");
      $display("and %0d random commands under stalls.", RANDOM_CMDS);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
